// File: hdl/uds_sar_pkg.sv
// Shared types and constants for the UDS security access responder.
`timescale 1ns / 1ps
`default_nettype none

package uds_sar_pkg;

  localparam int ID_BITS = 11;
  localparam int SEED_BITS = 16;
  localparam int CFG_IDX_BITS = 2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_REQUEST_ID  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESPONSE_ID = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEED_VALUE  = 2'd2;

  localparam logic [ID_BITS-1:0] REQUEST_ID_RST  = ID_BITS'(2016);
  localparam logic [ID_BITS-1:0] RESPONSE_ID_RST = ID_BITS'(2024);

  // Service codes and reply bytes
  localparam logic [7:0] SID_SECURITY_ACCESS = 8'h27;
  localparam logic [7:0] SID_ECU_RESET       = 8'h11;
  localparam logic [7:0] POS_SECURITY_ACCESS = 8'h67;
  localparam logic [7:0] POS_ECU_RESET       = 8'h51;
  localparam logic [7:0] NEGATIVE_SID        = 8'h7F;
  localparam logic [7:0] NRC_INVALID_KEY     = 8'h35;
  localparam logic [7:0] NRC_SECURITY_DENIED = 8'h33;
  localparam logic [7:0] SUB_SEED_REQUEST    = 8'h01;
  localparam logic [7:0] SUB_KEY_SEND        = 8'h02;
  localparam logic [7:0] SUB_HARD_RESET      = 8'h01;
  localparam logic [7:0] PAD_BYTE            = 8'hAA;
  localparam logic [3:0] LEN_MASK            = 4'h0F;
  localparam logic [3:0] LEN_MAX             = 4'd7;

  localparam logic [SEED_BITS-1:0] KEY_XOR = 16'h1234;
  localparam logic [SEED_BITS-1:0] KEY_ADD = 16'h1111;

  typedef struct packed {
    logic [ID_BITS-1:0] frame_id;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] reply_id;
    logic [3:0] reply_byte0;
    logic [7:0] reply_byte1;
    logic [7:0] reply_byte2;
    logic [7:0] reply_byte3;
    logic [7:0] reply_byte4;
    logic [7:0] reply_byte5;
    logic [7:0] reply_byte6;
    logic [7:0] reply_byte7;
    logic       unlocked_now;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   request_id;
    logic [ID_BITS-1:0]   response_id;
    logic [SEED_BITS-1:0] seed_value;
  } cfg_t;

  // State update produced by the decoder for one frame
  typedef struct packed {
    logic                 emit;
    logic                 key_we;
    logic [SEED_BITS-1:0] key_val;
    logic                 unlk_we;
    logic                 unlk_val;
  } upd_t;

  function automatic logic [SEED_BITS-1:0] derive_key(input logic [SEED_BITS-1:0] seed);
    derive_key = (seed ^ KEY_XOR) + KEY_ADD;
  endfunction

endpackage

`default_nettype wire

// File: hdl/uds_sar_cfg.sv
// Configuration register file of the UDS security access responder.
`timescale 1ns / 1ps
`default_nettype none

module uds_sar_cfg
  import uds_sar_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SEED_BITS-1:0]    cfg_wdata,
  output cfg_t                         cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_REQUEST_ID:  cfg_nxt.request_id  = cfg_wdata[ID_BITS-1:0];
        REG_RESPONSE_ID: cfg_nxt.response_id = cfg_wdata[ID_BITS-1:0];
        REG_SEED_VALUE:  cfg_nxt.seed_value  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.request_id  <= REQUEST_ID_RST;
      cfg_r.response_id <= RESPONSE_ID_RST;
      cfg_r.seed_value  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/uds_sar_decode.sv
// Request decoder and reply builder for one received frame.
`timescale 1ns / 1ps
`default_nettype none

module uds_sar_decode
  import uds_sar_pkg::*;
(
  input  wire in_item_t        req,
  input  wire cfg_t            cfg,
  input  wire logic            unlocked,
  input  wire logic [SEED_BITS-1:0] expected_key,
  output out_item_t            rsp,
  output upd_t                 upd
);

  logic [3:0] len_raw;
  logic [3:0] len;
  logic       id_hit;
  logic       is_sa;
  logic       is_seed;
  logic       is_key;
  logic       key_ok;
  logic       is_reset;
  logic [3:0] n;
  logic [7:0] pl0, pl1, pl2, pl3;

  always_comb begin
    len_raw  = req.byte0[3:0] & LEN_MASK;
    len      = (len_raw > LEN_MAX) ? LEN_MAX : len_raw;
    id_hit   = (req.frame_id == cfg.request_id) && (len != 4'd0);
    is_sa    = id_hit && (req.byte1 == SID_SECURITY_ACCESS) && (len >= 4'd2);
    is_seed  = is_sa && (req.byte2 == SUB_SEED_REQUEST);
    is_key   = is_sa && (req.byte2 == SUB_KEY_SEND) && (len >= 4'd4);
    key_ok   = ({req.byte3, req.byte4} == expected_key);
    is_reset = id_hit && (req.byte1 == SID_ECU_RESET);

    upd          = '0;
    upd.key_val  = derive_key(cfg.seed_value);
    upd.emit     = is_seed || is_key || is_reset;
    upd.key_we   = is_seed;
    upd.unlk_we  = (is_key && key_ok) || (is_reset && unlocked);
    upd.unlk_val = is_key;

    n   = 4'd3;
    pl0 = NEGATIVE_SID;
    pl1 = SID_ECU_RESET;
    pl2 = NRC_SECURITY_DENIED;
    pl3 = PAD_BYTE;
    if (is_seed) begin
      n   = 4'd4;
      pl0 = POS_SECURITY_ACCESS;
      pl1 = SUB_SEED_REQUEST;
      pl2 = cfg.seed_value[15:8];
      pl3 = cfg.seed_value[7:0];
    end else if (is_key && key_ok) begin
      n   = 4'd2;
      pl0 = POS_SECURITY_ACCESS;
      pl1 = SUB_KEY_SEND;
      pl2 = PAD_BYTE;
    end else if (is_key) begin
      pl1 = SID_SECURITY_ACCESS;
      pl2 = NRC_INVALID_KEY;
    end else if (unlocked) begin
      n   = 4'd2;
      pl0 = POS_ECU_RESET;
      pl1 = SUB_HARD_RESET;
      pl2 = PAD_BYTE;
    end

    rsp.reply_id     = cfg.response_id;
    rsp.reply_byte0  = n;
    rsp.reply_byte1  = pl0;
    rsp.reply_byte2  = pl1;
    rsp.reply_byte3  = pl2;
    rsp.reply_byte4  = pl3;
    rsp.reply_byte5  = PAD_BYTE;
    rsp.reply_byte6  = PAD_BYTE;
    rsp.reply_byte7  = PAD_BYTE;
    rsp.unlocked_now = upd.unlk_we ? upd.unlk_val : unlocked;
  end

endmodule

`default_nettype wire

// File: hdl/uds_security_access_responder_core.sv
// Top level of the UDS security access responder: frame and reply pipeline, unlock state.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_*      input      in_valid/in_stall   in_item_t: received CAN frame
// out_*     output     out_valid/out_stall out_item_t: single-frame reply
// cfg_*     input      cfg_we              cfg_index/cfg_wdata: register write
//
// A frame passes through the input register, then the reply register. One
// frame is accepted every cycle while in_stall is low; the input register
// drains into the reply register whenever that register is empty or being
// taken. Frames that cause no reply just drop out of the input register.
// Unlock flag and expected key update as a frame leaves the input register,
// so frames are handled strictly in order. Reset (rst_n low, synchronous)
// empties both registers, relocks and clears the expected key.

module uds_security_access_responder_core
  import uds_sar_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire in_item_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output out_item_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SEED_BITS-1:0]    cfg_wdata
);

  cfg_t      cfg;
  out_item_t rsp;
  upd_t      upd;

  logic                 s1_valid_r, s1_valid_nxt;
  in_item_t             s1_data_r, s1_data_nxt;
  logic                 s2_valid_r, s2_valid_nxt;
  out_item_t            s2_data_r, s2_data_nxt;
  logic                 unlocked_r, unlocked_nxt;
  logic [SEED_BITS-1:0] key_r, key_nxt;

  logic s2_free;
  logic s1_adv;
  logic in_take;

  uds_sar_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uds_sar_decode u_decode (
    .req          (s1_data_r),
    .cfg          (cfg),
    .unlocked     (unlocked_r),
    .expected_key (key_r),
    .rsp          (rsp),
    .upd          (upd)
  );

  // Reply register is free when empty or being taken this cycle
  assign s2_free  = !s2_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_data_nxt  = s1_data_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_data;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    s2_data_nxt  = s2_data_r;
    if (s1_adv) begin
      // drop frames that cause no reply
      s2_valid_nxt = upd.emit;
      s2_data_nxt  = rsp;
    end else if (s2_valid_r && !out_stall) begin
      s2_valid_nxt = 1'b0;
    end

    unlocked_nxt = unlocked_r;
    key_nxt      = key_r;
    if (s1_adv && upd.unlk_we) begin
      unlocked_nxt = upd.unlk_val;
    end
    if (s1_adv && upd.key_we) begin
      key_nxt = upd.key_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      unlocked_r <= 1'b0;
      key_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      unlocked_r <= unlocked_nxt;
      key_r      <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r <= s1_data_nxt;
    s2_data_r <= s2_data_nxt;
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

  // Replies are always two to four payload bytes long
  a_reply_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.reply_byte0 == 4'd2 || out_data.reply_byte0 == 4'd3 ||
                   out_data.reply_byte0 == 4'd4))
    else $error("reply length out of range");

  // A positive key reply always reports the block unlocked
  a_key_unlocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_byte1 == POS_SECURITY_ACCESS &&
    out_data.reply_byte2 == SUB_KEY_SEND |-> out_data.unlocked_now)
    else $error("key accepted but not unlocked");

  // A positive ECU reset reply always reports the block relocked
  a_reset_locks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_byte1 == POS_ECU_RESET |-> !out_data.unlocked_now)
    else $error("ECU reset did not relock");

  // Unlock flag only rises when a frame leaves the input register
  a_unlock_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(unlocked_r) |-> $past(s1_adv))
    else $error("unlock without a frame");

endmodule

`default_nettype wire

// File: bench/tb_uds_security_access_responder_core.sv
// Self-checking testbench for the UDS security access responder core.
`timescale 1ns / 1ps

import uds_sar_pkg::*;

// Tracks unlock state and expected key, and queues the reply each frame should cause.
class security_reply_predictor;
  logic [ID_BITS-1:0]   req_id;
  logic [ID_BITS-1:0]   resp_id;
  logic [SEED_BITS-1:0] seed;
  logic                 unlock_flag;
  logic [SEED_BITS-1:0] armed_key;
  out_item_t            replies_due [$];
  int                   mismatches;
  string field_names [10] = '{"reply_id", "reply_byte0", "reply_byte1", "reply_byte2",
                              "reply_byte3", "reply_byte4", "reply_byte5", "reply_byte6",
                              "reply_byte7", "unlocked_now"};

  function new();
    req_id      = REQUEST_ID_RST;
    resp_id     = RESPONSE_ID_RST;
    seed        = '0;
    unlock_flag = 1'b0;
    armed_key   = '0;
    mismatches  = 0;
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  function void write_reg_shadow(logic [CFG_IDX_BITS-1:0] idx, logic [SEED_BITS-1:0] data);
    case (idx)
      REG_REQUEST_ID:  req_id  = data[ID_BITS-1:0];
      REG_RESPONSE_ID: resp_id = data[ID_BITS-1:0];
      REG_SEED_VALUE:  seed    = data;
      default: ;
    endcase
  endfunction

  function void note_frame(in_item_t f);
    logic [3:0] len;
    out_item_t  r;
    logic       hit;
    if (f.frame_id != req_id) return;
    len = f.byte0[3:0];
    if (len > LEN_MAX) len = LEN_MAX;
    if (len == 0) return;
    hit = 1'b0;
    r = '0;
    r.reply_id    = resp_id;
    r.reply_byte2 = PAD_BYTE;
    r.reply_byte3 = PAD_BYTE;
    r.reply_byte4 = PAD_BYTE;
    r.reply_byte5 = PAD_BYTE;
    r.reply_byte6 = PAD_BYTE;
    r.reply_byte7 = PAD_BYTE;
    if (f.byte1 == SID_SECURITY_ACCESS && len >= 2) begin
      if (f.byte2 == SUB_SEED_REQUEST) begin
        armed_key     = (seed ^ KEY_XOR) + KEY_ADD;
        r.reply_byte0 = 4'd4;
        r.reply_byte1 = POS_SECURITY_ACCESS;
        r.reply_byte2 = SUB_SEED_REQUEST;
        r.reply_byte3 = seed[15:8];
        r.reply_byte4 = seed[7:0];
        hit = 1'b1;
      end else if (f.byte2 == SUB_KEY_SEND && len >= 4) begin
        if ({f.byte3, f.byte4} == armed_key) begin
          unlock_flag   = 1'b1;
          r.reply_byte0 = 4'd2;
          r.reply_byte1 = POS_SECURITY_ACCESS;
          r.reply_byte2 = SUB_KEY_SEND;
        end else begin
          r.reply_byte0 = 4'd3;
          r.reply_byte1 = NEGATIVE_SID;
          r.reply_byte2 = SID_SECURITY_ACCESS;
          r.reply_byte3 = NRC_INVALID_KEY;
        end
        hit = 1'b1;
      end
    end else if (f.byte1 == SID_ECU_RESET) begin
      if (unlock_flag) begin
        unlock_flag   = 1'b0;
        r.reply_byte0 = 4'd2;
        r.reply_byte1 = POS_ECU_RESET;
        r.reply_byte2 = SUB_HARD_RESET;
      end else begin
        r.reply_byte0 = 4'd3;
        r.reply_byte1 = NEGATIVE_SID;
        r.reply_byte2 = SID_ECU_RESET;
        r.reply_byte3 = NRC_SECURITY_DENIED;
      end
      hit = 1'b1;
    end
    if (hit) begin
      r.unlocked_now = unlock_flag;
      replies_due.insert(replies_due.size(), r);
    end
  endfunction

  function void unpack_fields(out_item_t r, output logic [15:0] v [10]);
    v[0] = 16'(r.reply_id);
    v[1] = 16'(r.reply_byte0);
    v[2] = 16'(r.reply_byte1);
    v[3] = 16'(r.reply_byte2);
    v[4] = 16'(r.reply_byte3);
    v[5] = 16'(r.reply_byte4);
    v[6] = 16'(r.reply_byte5);
    v[7] = 16'(r.reply_byte6);
    v[8] = 16'(r.reply_byte7);
    v[9] = 16'(r.unlocked_now);
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_reply(out_item_t got);
    out_item_t   want;
    logic [15:0] g [10];
    logic [15:0] w [10];
    if (replies_due.size() == 0) begin
      report($sformatf("reply %h arrived with no frame pending", got));
      return;
    end
    want = replies_due.pop_front();
    unpack_fields(got, g);
    unpack_fields(want, w);
    for (int i = 0; i < 10; i++) begin
      if (g[i] !== w[i])
        report($sformatf("%s: got %h, expected %h", field_names[i], g[i], w[i]));
    end
  endtask
endclass

module tb_uds_security_access_responder_core;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off to back the block up
  localparam int SETTLE_CYCLES = 6;     // two-stage pipeline plus margin
  localparam int PHASE_QUOTA   = 290;   // answered-id frames per random phase

  // Index past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef enum int {K_SEED, K_KEY_GOOD, K_KEY_BAD, K_RESET, K_NOISE, K_FOREIGN} frame_kind_e;
  typedef enum int {ST_NONE, ST_COIN, ST_PERIODIC, ST_SPARSE} stall_mode_e;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_stall;
  out_item_t               out_data;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SEED_BITS-1:0]    cfg_wdata;

  security_reply_predictor pred = new();

  // Register values the stimulus aims at; the predictor keeps its own shadow.
  logic [ID_BITS-1:0]   cur_req;
  logic [SEED_BITS-1:0] cur_seed;
  int                   burst_left;
  bit                   hold_req;

  uds_security_access_responder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run with a failure if it runs past its cycle limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Sample every handshake on the pre-edge values. Register writes land in the
  // shadow first, accepted frames queue their reply, accepted replies are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) pred.write_reg_shadow(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) pred.note_frame(in_data);
      if (out_valid && !out_stall) pred.check_reply(out_data);
    end
  end

  // Receiver: stall on randomly chosen patterns, one change per edge at most.
  // On request, hold off for a long stretch so the pipeline fills and stalls input.
  initial begin
    stall_mode_e mode;
    int          left;
    int          step;
    out_stall <= 1'b0;
    mode = ST_NONE;
    left = 0;
    step = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left = $urandom_range(8, 60);
        end
        left--;
        step++;
        case (mode)
          ST_NONE:     out_stall <= 1'b0;
          ST_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
          ST_PERIODIC: out_stall <= (step % 3 == 0);
          default:     out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic [SEED_BITS-1:0] matching_key();
    return (cur_seed ^ KEY_XOR) + KEY_ADD;
  endfunction

  // Build a frame on the current request id; trailing bytes are random.
  function automatic in_item_t frame(logic [7:0] b0, logic [7:0] sid, logic [7:0] sub,
                                     logic [15:0] key);
    in_item_t f;
    f.frame_id = cur_req;
    f.byte0    = b0;
    f.byte1    = sid;
    f.byte2    = sub;
    f.byte3    = key[15:8];
    f.byte4    = key[7:0];
    f.byte5    = 8'($urandom);
    f.byte6    = 8'($urandom);
    f.byte7    = 8'($urandom);
    return f;
  endfunction

  // Upper nibble of byte0 is always random; the low nibble sets the length.
  function automatic in_item_t make_frame(frame_kind_e kind);
    in_item_t           f;
    logic [7:0]         b0;
    logic [7:0]         sid;
    logic [7:0]         sub;
    logic [ID_BITS-1:0] id;
    b0 = 8'($urandom);
    case (kind)
      K_SEED:
        f = frame({b0[7:4], 4'($urandom_range(2, 15))}, SID_SECURITY_ACCESS,
                  SUB_SEED_REQUEST, 16'($urandom));
      K_KEY_GOOD:
        f = frame({b0[7:4], 4'($urandom_range(4, 15))}, SID_SECURITY_ACCESS,
                  SUB_KEY_SEND, matching_key());
      K_KEY_BAD:
        f = frame({b0[7:4], 4'($urandom_range(2, 15))}, SID_SECURITY_ACCESS,
                  SUB_KEY_SEND, 16'($urandom));
      K_RESET:
        f = frame({b0[7:4], 4'($urandom_range(1, 15))}, SID_ECU_RESET,
                  8'($urandom), 16'($urandom));
      K_NOISE: begin
        sid = ($urandom_range(0, 2) == 0) ? SID_SECURITY_ACCESS :
              ($urandom_range(0, 1) == 0) ? SID_ECU_RESET : 8'($urandom);
        sub = ($urandom_range(0, 2) == 0) ? SUB_SEED_REQUEST :
              ($urandom_range(0, 1) == 0) ? SUB_KEY_SEND : 8'($urandom);
        f = frame(b0, sid, sub, 16'($urandom));
      end
      default: begin
        f  = frame(b0, 8'($urandom), 8'($urandom), 16'($urandom));
        id = 11'($urandom);
        while (id == cur_req) id = 11'($urandom);
        f.frame_id = id;
      end
    endcase
    return f;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_frame(in_item_t f);
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender pacing: bursts of random length separated by random idle gaps.
  task automatic send_paced(in_item_t f);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 25);
    end
    burst_left--;
    send_frame(f);
  endtask

  // Drop valid, wait for every queued reply, then let the pipeline empty out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SEED_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Program all registers; ids carry random upper bits that must be dropped.
  task automatic configure(logic [ID_BITS-1:0] req, logic [ID_BITS-1:0] resp,
                           logic [SEED_BITS-1:0] seed);
    write_reg(REG_REQUEST_ID, {5'($urandom), req});
    write_reg(REG_RESPONSE_ID, {5'($urandom), resp});
    write_reg(REG_SEED_VALUE, seed);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we  <= 1'b0;
    cur_req  = req;
    cur_seed = seed;
  endtask

  // Mostly well-formed seed/key/reset exchanges, the rest noise and foreign ids.
  // Foreign-id frames are ignored by the block and do not count toward the quota.
  task automatic run_random(int quota);
    int n;
    n = 0;
    while (n < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        send_paced(make_frame(K_SEED));
        n++;
        if ($urandom_range(0, 3) != 0) send_paced(make_frame(K_KEY_GOOD));
        else send_paced(make_frame(K_KEY_BAD));
        n++;
        if ($urandom_range(0, 2) == 0) begin
          send_paced(make_frame(K_KEY_GOOD));
          n++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send_paced(make_frame(K_RESET));
          n++;
        end
      end else if ($urandom_range(0, 3) == 0) begin
        send_paced(make_frame(K_FOREIGN));
      end else begin
        send_paced(make_frame(K_NOISE));
        n++;
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    cur_req     = REQUEST_ID_RST;
    cur_seed    = '0;
    burst_left  = 0;
    hold_req    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass on the reset register values.
    send_paced(frame(8'h01, SID_ECU_RESET, 8'h00, 16'h0000));          // reset while locked
    send_paced(frame(8'h01, SID_SECURITY_ACCESS, SUB_SEED_REQUEST, 16'h0000)); // too short
    send_paced(frame(8'h00, SID_SECURITY_ACCESS, SUB_SEED_REQUEST, 16'h0000)); // zero length
    send_paced(frame(8'hF0, SID_ECU_RESET, 8'hFF, 16'hFFFF));          // upper nibble only
    send_paced(frame(8'h02, SID_SECURITY_ACCESS, SUB_SEED_REQUEST, 16'h0000));
    send_paced(frame(8'h03, SID_SECURITY_ACCESS, SUB_KEY_SEND, matching_key())); // short key
    send_paced(frame(8'h04, SID_SECURITY_ACCESS, SUB_KEY_SEND, ~matching_key()));
    send_paced(frame(8'h0F, SID_SECURITY_ACCESS, SUB_KEY_SEND, matching_key())); // capped len
    send_paced(frame(8'h07, SID_SECURITY_ACCESS, 8'h03, 16'h0000));    // unknown subfunction
    send_paced(frame(8'h07, 8'h22, SUB_SEED_REQUEST, 16'h0000));       // other service
    send_paced(make_frame(K_FOREIGN));
    send_paced(frame(8'hFF, SID_ECU_RESET, 8'hFF, 16'hFFFF));          // relock
    send_paced(frame(8'hF1, SID_ECU_RESET, 8'h00, 16'h0000));          // denied again
    send_paced(frame(8'h08, 8'h00, 8'h00, 16'h0000));
    send_paced(frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    send_paced(frame(8'h05, SID_SECURITY_ACCESS, SUB_SEED_REQUEST, 16'hFFFF));
    send_paced(frame(8'h04, SID_SECURITY_ACCESS, SUB_KEY_SEND, matching_key()));
    send_paced(frame(8'h02, SID_SECURITY_ACCESS, SUB_SEED_REQUEST, 16'h0000)); // re-arm, stay open
    send_paced(frame(8'h01, SID_ECU_RESET, 8'h01, 16'h0000));
    settle();

    // Extreme settings, with the long receiver hold-off at the start of the first.
    configure(11'd0, 11'd2047, 16'hFFFF);
    hold_req = 1'b1;
    run_random(PHASE_QUOTA);
    settle();

    configure(11'd2047, 11'd0, 16'h0000);
    run_random(PHASE_QUOTA);
    settle();

    // Random settings.
    repeat (3) begin
      configure(11'($urandom), 11'($urandom), 16'($urandom));
      run_random(PHASE_QUOTA);
      settle();
    end

    if (pred.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
